// ===== src/pdsd_pkg.sv =====
package pdsd_pkg;

    localparam int ELEM_W   = 6;
    localparam int ELEM_N   = 1 << ELEM_W;
    localparam int BRIGHT_W = 8;
    localparam int TIME_W   = 32;
    localparam int COLON_W  = 4;
    localparam int DOT_IDX_W = 2;
    localparam int DIV_CNT_W = $clog2(TIME_W);
    localparam int FUNC_W   = 3;

    // first colon dot element
    localparam logic [ELEM_W-1:0] DOT_BASE = 6'd60;

    localparam logic [BRIGHT_W-1:0] LEVELS_RESET = 8'd16;

    localparam logic [FUNC_W-1:0] FN_SET_BRIGHT  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SET_SLOT    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_TICK        = 3'd2;
    localparam logic [FUNC_W-1:0] FN_READ_BRIGHT = 3'd3;
    localparam logic [FUNC_W-1:0] FN_FILL        = 3'd4;

    localparam logic RK_SHIFT = 1'b0;
    localparam logic RK_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_EMIT,
        ST_READ
    } t_state;

endpackage

// ===== src/pdsd_in_if.sv =====
interface pdsd_in_if;
    logic                            valid;
    logic                            ready;
    logic [pdsd_pkg::FUNC_W-1:0]     func;
    logic [pdsd_pkg::ELEM_W-1:0]     element_index;
    logic [pdsd_pkg::BRIGHT_W-1:0]   brightness;
    logic [pdsd_pkg::ELEM_W-1:0]     pin_slot;
    logic [pdsd_pkg::TIME_W-1:0]     time_ms;

    modport source (
        output valid, func, element_index, brightness, pin_slot, time_ms,
        input  ready
    );
    modport sink (
        input  valid, func, element_index, brightness, pin_slot, time_ms,
        output ready
    );
endinterface

// ===== src/pdsd_out_if.sv =====
interface pdsd_out_if;
    logic                            valid;
    logic                            ready;
    logic                            result_kind;
    logic                            serial_bit;
    logic                            last;
    logic [pdsd_pkg::COLON_W-1:0]    colon_levels;
    logic [pdsd_pkg::BRIGHT_W-1:0]   read_value;

    modport source (
        output valid, result_kind, serial_bit, last, colon_levels, read_value,
        input  ready
    );
    modport sink (
        input  valid, result_kind, serial_bit, last, colon_levels, read_value,
        output ready
    );
endinterface

// ===== src/pdsd_cfg_if.sv =====
interface pdsd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pdsd_pkg::BRIGHT_W-1:0]   data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

// ===== src/pwm_display_shift_driver.sv =====
// software pwm driver for a display of shifted digit cathodes and direct colon dots.
// brightness per element and the slot map per digit live in two block rams; both give
// their read data from a register in the cycle after the address. set brightness, set
// slot and fill are done as they are taken and leave the block idle; fill only records
// the value and drops the per-element written flags, so any element not written since
// reads back the fill value (reset acts as a fill with zero). a read answer passes from
// the ram register into the output register once that is free. a tick first forms
// time_ms mod levels (one remainder bit per cycle), then scans both rams through their
// single read port, then sends one shift bit at a time while the sink takes it. no new
// item is taken before the last bit of a tick or the read answer sits in the output
// register; that register then lets the next item in while it waits.
module pwm_display_shift_driver #(
    parameter int TUBES           = 6,
    parameter int DIGITS_PER_TUBE = 10,
    parameter int COLONS          = 2,
    parameter int DOTS_PER_COLON  = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pdsd_in_if.sink     i_in,
    pdsd_out_if.source  o_out,
    pdsd_cfg_if.sink    i_cfg
);

    // element counts
    localparam int NDIG = TUBES * DIGITS_PER_TUBE;
    localparam int NDOT = COLONS * DOTS_PER_COLON;
    // slot numbers and slot ram addresses
    localparam int SAW  = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int SN   = 1 << SAW;

    localparam logic [pdsd_pkg::ELEM_W-1:0] LAST_DIGIT = pdsd_pkg::ELEM_W'(NDIG - 1);
    localparam logic [pdsd_pkg::ELEM_W-1:0] LAST_DOT   =
        pdsd_pkg::ELEM_W'(int'(pdsd_pkg::DOT_BASE) + NDOT - 1);

    pdsd_pkg::t_state r_state, n_state;

    // configuration
    logic [pdsd_pkg::BRIGHT_W-1:0] r_levels;

    // brightness written flags and the value for unwritten entries
    logic [pdsd_pkg::ELEM_N-1:0]   r_bvalid, n_bvalid;
    logic [pdsd_pkg::BRIGHT_W-1:0] r_fill, n_fill;
    // slot map written flags, unwritten digits map to themselves
    logic [SN-1:0]                 r_svalid, n_svalid;

    // remainder unit
    logic [pdsd_pkg::BRIGHT_W-1:0]  r_rem, n_rem;
    logic [pdsd_pkg::BRIGHT_W-1:0]  r_per, n_per;
    logic [pdsd_pkg::TIME_W-1:0]    r_tsh, n_tsh;
    logic [pdsd_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic [pdsd_pkg::BRIGHT_W:0]    w_sh;
    logic [pdsd_pkg::BRIGHT_W:0]    w_sh_sub;

    // scan
    logic [pdsd_pkg::ELEM_W-1:0] r_addr, n_addr;
    logic                        r_issue, n_issue;
    logic                        r_p_valid, n_p_valid;
    logic [pdsd_pkg::ELEM_W-1:0] r_q_addr;
    logic [NDIG-1:0]             r_slot_vec, n_slot_vec;
    logic [pdsd_pkg::COLON_W-1:0] r_colons, n_colons;
    logic [SAW-1:0]              r_bit, n_bit;
    logic                        r_rd_ok, n_rd_ok;

    // output register
    logic                          r_o_valid, n_o_valid;
    logic                          r_o_kind, n_o_kind;
    logic                          r_o_bit, n_o_bit;
    logic                          r_o_last, n_o_last;
    logic [pdsd_pkg::COLON_W-1:0]  r_o_colons, n_o_colons;
    logic [pdsd_pkg::BRIGHT_W-1:0] r_o_read, n_o_read;

    // ram ports
    logic [pdsd_pkg::ELEM_W-1:0]   w_raddr;
    logic                          w_b_we;
    logic [pdsd_pkg::BRIGHT_W-1:0] w_bq;
    logic                          w_s_we;
    logic [SAW-1:0]                w_sq;

    // decoded values
    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_in_digit;
    logic                          w_in_elem;
    logic                          w_slot_ok;
    logic [pdsd_pkg::BRIGHT_W-1:0] w_bright;
    logic [SAW-1:0]                w_slot;
    logic [pdsd_pkg::ELEM_W-1:0]   w_dot_off;
    logic [pdsd_pkg::DOT_IDX_W-1:0] w_dot;
    logic [pdsd_pkg::ELEM_W-1:0]   w_in_dot_off;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == pdsd_pkg::ST_IDLE);
    assign w_accept    = i_in.valid && (r_state == pdsd_pkg::ST_IDLE);
    assign w_out_free  = !r_o_valid || o_out.ready;

    assign o_out.valid        = r_o_valid;
    assign o_out.result_kind  = r_o_kind;
    assign o_out.serial_bit   = r_o_bit;
    assign o_out.last         = r_o_last;
    assign o_out.colon_levels = r_o_colons;
    assign o_out.read_value   = r_o_read;

    // element classification of the incoming item
    assign w_in_dot_off = i_in.element_index - pdsd_pkg::DOT_BASE;
    assign w_in_digit   = i_in.element_index < pdsd_pkg::ELEM_W'(NDIG);
    assign w_in_elem    = w_in_digit ||
                          (i_in.element_index >= pdsd_pkg::DOT_BASE &&
                           w_in_dot_off < pdsd_pkg::ELEM_W'(NDOT));
    assign w_slot_ok    = w_in_digit && (i_in.pin_slot < pdsd_pkg::ELEM_W'(NDIG));

    // one read address for both rams: the item's element when idle, else the scan pointer
    assign w_raddr = (r_state == pdsd_pkg::ST_IDLE) ? i_in.element_index : r_addr;

    assign w_b_we = w_accept && (i_in.func == pdsd_pkg::FN_SET_BRIGHT) && w_in_elem;
    assign w_s_we = w_accept && (i_in.func == pdsd_pkg::FN_SET_SLOT) && w_slot_ok;

    pdsd_ram #(
        .WIDTH (pdsd_pkg::BRIGHT_W),
        .DEPTH (pdsd_pkg::ELEM_N)
    ) u_bright_ram (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (i_in.element_index),
        .i_wdata (i_in.brightness),
        .i_raddr (w_raddr),
        .o_rdata (w_bq)
    );

    pdsd_ram #(
        .WIDTH (SAW),
        .DEPTH (NDIG)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_s_we),
        .i_waddr (i_in.element_index[SAW-1:0]),
        .i_wdata (i_in.pin_slot[SAW-1:0]),
        .i_raddr (w_raddr[SAW-1:0]),
        .o_rdata (w_sq)
    );

    // ram data with the written flags applied, for the address read last cycle
    assign w_bright  = r_bvalid[r_q_addr] ? w_bq : r_fill;
    assign w_slot    = r_svalid[r_q_addr[SAW-1:0]] ? w_sq : r_q_addr[SAW-1:0];
    assign w_dot_off = r_q_addr - pdsd_pkg::DOT_BASE;
    assign w_dot     = w_dot_off[pdsd_pkg::DOT_IDX_W-1:0];

    // one restoring remainder step, the remainder stays below the period
    assign w_sh     = {r_rem, r_tsh[pdsd_pkg::TIME_W-1]};
    assign w_sh_sub = w_sh - {1'b0, r_per};

    always_comb begin
        n_state    = r_state;
        n_bvalid   = r_bvalid;
        n_fill     = r_fill;
        n_svalid   = r_svalid;
        n_rem      = r_rem;
        n_per      = r_per;
        n_tsh      = r_tsh;
        n_div_cnt  = r_div_cnt;
        n_addr     = r_addr;
        n_issue    = r_issue;
        n_p_valid  = 1'b0;
        n_slot_vec = r_slot_vec;
        n_colons   = r_colons;
        n_bit      = r_bit;
        n_rd_ok    = r_rd_ok;
        n_o_valid  = r_o_valid && !o_out.ready;
        n_o_kind   = r_o_kind;
        n_o_bit    = r_o_bit;
        n_o_last   = r_o_last;
        n_o_colons = r_o_colons;
        n_o_read   = r_o_read;

        case (r_state)
            pdsd_pkg::ST_IDLE: begin
                n_addr = i_in.element_index;
                if (w_accept) begin
                    case (i_in.func)
                        pdsd_pkg::FN_SET_BRIGHT: begin
                            if (w_in_elem) begin
                                n_bvalid[i_in.element_index] = 1'b1;
                            end
                        end
                        pdsd_pkg::FN_SET_SLOT: begin
                            if (w_slot_ok) begin
                                n_svalid[i_in.element_index[SAW-1:0]] = 1'b1;
                            end
                        end
                        pdsd_pkg::FN_TICK: begin
                            // levels of zero counts as a period of one
                            n_per     = (r_levels == '0) ? pdsd_pkg::BRIGHT_W'(1) : r_levels;
                            n_rem     = '0;
                            n_tsh     = i_in.time_ms;
                            n_div_cnt = pdsd_pkg::DIV_CNT_W'(pdsd_pkg::TIME_W - 1);
                            n_state   = pdsd_pkg::ST_DIV;
                        end
                        pdsd_pkg::FN_READ_BRIGHT: begin
                            n_rd_ok = w_in_elem;
                            n_state = pdsd_pkg::ST_READ;
                        end
                        pdsd_pkg::FN_FILL: begin
                            // every element now reads the fill value until written
                            n_bvalid = '0;
                            n_fill   = i_in.brightness;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            pdsd_pkg::ST_DIV: begin
                n_rem = w_sh_sub[pdsd_pkg::BRIGHT_W] ? w_sh[pdsd_pkg::BRIGHT_W-1:0]
                                                     : w_sh_sub[pdsd_pkg::BRIGHT_W-1:0];
                n_tsh = {r_tsh[pdsd_pkg::TIME_W-2:0], 1'b0};
                n_div_cnt = r_div_cnt - 1'b1;
                if (r_div_cnt == '0) begin
                    // start the scan at digit zero with every slot dark
                    n_addr     = '0;
                    n_issue    = 1'b1;
                    n_slot_vec = '1;
                    n_colons   = '0;
                    n_state    = pdsd_pkg::ST_SCAN;
                end
            end

            pdsd_pkg::ST_SCAN: begin
                // issue side: digits, then jump to the colon dots
                if (r_issue) begin
                    n_p_valid = 1'b1;
                    if (r_addr == LAST_DOT) begin
                        n_issue = 1'b0;
                    end else if (r_addr == LAST_DIGIT) begin
                        n_addr = pdsd_pkg::DOT_BASE;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                // data side: compare against the pwm phase held in r_rem
                if (r_p_valid) begin
                    if (w_bright > r_rem) begin
                        if (r_q_addr < pdsd_pkg::ELEM_W'(NDIG)) begin
                            n_slot_vec[w_slot] = 1'b0;
                        end else begin
                            n_colons[w_dot] = 1'b1;
                        end
                    end
                end else if (!r_issue) begin
                    n_bit   = SAW'(NDIG - 1);
                    n_state = pdsd_pkg::ST_EMIT;
                end
            end

            pdsd_pkg::ST_EMIT: begin
                // highest slot first, colon levels ride on the last bit
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = pdsd_pkg::RK_SHIFT;
                    n_o_bit    = r_slot_vec[r_bit];
                    n_o_last   = (r_bit == '0);
                    n_o_colons = (r_bit == '0) ? r_colons : '0;
                    n_o_read   = '0;
                    if (r_bit == '0) begin
                        n_state = pdsd_pkg::ST_IDLE;
                    end else begin
                        n_bit = r_bit - 1'b1;
                    end
                end
            end

            pdsd_pkg::ST_READ: begin
                // r_addr holds the element, so the ram output stays put while stalled
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = pdsd_pkg::RK_READ;
                    n_o_bit    = 1'b0;
                    n_o_last   = 1'b0;
                    n_o_colons = '0;
                    n_o_read   = r_rd_ok ? w_bright : '0;
                    n_state    = pdsd_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = pdsd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pdsd_pkg::ST_IDLE;
        end else begin
            r_state    <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels   <= pdsd_pkg::LEVELS_RESET;
            r_bvalid   <= '0;
            r_fill     <= '0;
            r_svalid   <= '0;
            r_div_cnt  <= '0;
            r_issue    <= 1'b0;
            r_p_valid  <= 1'b0;
            r_slot_vec <= '1;
            r_colons   <= '0;
            r_bit      <= '0;
            r_rd_ok    <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_levels <= i_cfg.data;
            end
            r_bvalid   <= n_bvalid;
            r_fill     <= n_fill;
            r_svalid   <= n_svalid;
            r_div_cnt  <= n_div_cnt;
            r_issue    <= n_issue;
            r_p_valid  <= n_p_valid;
            r_slot_vec <= n_slot_vec;
            r_colons   <= n_colons;
            r_bit      <= n_bit;
            r_rd_ok    <= n_rd_ok;
            r_o_valid  <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_per      <= n_per;
        r_tsh      <= n_tsh;
        r_addr     <= n_addr;
        r_q_addr   <= w_raddr;
        r_o_kind   <= n_o_kind;
        r_o_bit    <= n_o_bit;
        r_o_last   <= n_o_last;
        r_o_colons <= n_o_colons;
        r_o_read   <= n_o_read;
    end

endmodule

// ===== src/pdsd_ram.sv =====
module pdsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== dv/pwm_display_shift_driver_tb.sv =====
`timescale 1ns / 100ps

module pwm_display_shift_driver_tb;

    // display sizes at the default parameters
    localparam int N_DIGITS = 60;
    localparam int N_DOTS   = 4;

    // func codes that the block ignores
    localparam logic [pdsd_pkg::FUNC_W-1:0] FN_SPARE_LO = 3'd5;
    localparam logic [pdsd_pkg::FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 33;
    // quiet cycles after the last result before a period write
    localparam int SETTLE_CYCLES   = 16;
    // quiet margin before the verdict, longer than one tick without stalls
    localparam int TAIL_CYCLES     = 200;

    typedef struct packed {
        logic [pdsd_pkg::FUNC_W-1:0]   func;
        logic [pdsd_pkg::ELEM_W-1:0]   elem;
        logic [pdsd_pkg::BRIGHT_W-1:0] bright;
        logic [pdsd_pkg::ELEM_W-1:0]   slot;
        logic [pdsd_pkg::TIME_W-1:0]   time_ms;
    } t_cmd;

    typedef struct packed {
        logic                          kind;
        logic                          bit_val;
        logic                          last;
        logic [pdsd_pkg::COLON_W-1:0]  colons;
        logic [pdsd_pkg::BRIGHT_W-1:0] read_val;
    } t_disp_result;

    // directed row: typed marks a read whose answer is written in the row
    typedef struct packed {
        t_cmd                          cmd;
        logic                          typed;
        logic [pdsd_pkg::BRIGHT_W-1:0] read_exp;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    pdsd_in_if  in_if ();
    pdsd_out_if out_if ();
    pdsd_cfg_if cfg_if ();

    pwm_display_shift_driver DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // shadow of the display state
    logic [pdsd_pkg::BRIGHT_W-1:0] bright_mem [pdsd_pkg::ELEM_N];
    logic [pdsd_pkg::ELEM_W-1:0]   slot_of [N_DIGITS];
    logic [pdsd_pkg::BRIGHT_W-1:0] pwm_levels;

    // results still owed by the block, oldest first
    t_disp_result due_results [$];

    int src_idle_pct;
    int snk_idle_pct;
    int err_cnt;

    t_dir_row dir_tab [25] = '{
        // fresh after reset: everything dark
        '{'{pdsd_pkg::FN_READ_BRIGHT, 6'd0,  8'd0,   6'd0,  32'd0},          1'b1, 8'd0},
        '{'{pdsd_pkg::FN_READ_BRIGHT, 6'd63, 8'd0,   6'd0,  32'd0},          1'b1, 8'd0},
        '{'{pdsd_pkg::FN_TICK,        6'd0,  8'd0,   6'd0,  32'd0},          1'b0, 8'd0},
        // extremes of brightness on first digit, last dot, last digit
        '{'{pdsd_pkg::FN_SET_BRIGHT,  6'd0,  8'd255, 6'd0,  32'd0},          1'b0, 8'd0},
        '{'{pdsd_pkg::FN_SET_BRIGHT,  6'd63, 8'd255, 6'd0,  32'd0},          1'b0, 8'd0},
        '{'{pdsd_pkg::FN_SET_BRIGHT,  6'd59, 8'd1,   6'd0,  32'd0},          1'b0, 8'd0},
        '{'{pdsd_pkg::FN_READ_BRIGHT, 6'd0,  8'd0,   6'd0,  32'd0},          1'b1, 8'd255},
        '{'{pdsd_pkg::FN_TICK,        6'd0,  8'd0,   6'd0,  32'hFFFF_FFFF},  1'b0, 8'd0},
        // shared slots, out of range slot, slot write to a colon dot
        '{'{pdsd_pkg::FN_SET_SLOT,    6'd5,  8'd0,   6'd59, 32'd0},          1'b0, 8'd0},
        '{'{pdsd_pkg::FN_SET_SLOT,    6'd59, 8'd0,   6'd0,  32'd0},          1'b0, 8'd0},
        '{'{pdsd_pkg::FN_SET_SLOT,    6'd3,  8'd0,   6'd63, 32'd0},          1'b0, 8'd0},
        '{'{pdsd_pkg::FN_SET_SLOT,    6'd60, 8'd0,   6'd1,  32'd0},          1'b0, 8'd0},
        '{'{pdsd_pkg::FN_SET_BRIGHT,  6'd5,  8'd200, 6'd0,  32'd0},          1'b0, 8'd0},
        '{'{pdsd_pkg::FN_TICK,        6'd0,  8'd0,   6'd0,  32'd16},         1'b0, 8'd0},
        // fill all to full
        '{'{pdsd_pkg::FN_FILL,        6'd0,  8'd255, 6'd0,  32'd0},          1'b0, 8'd0},
        '{'{pdsd_pkg::FN_READ_BRIGHT, 6'd31, 8'd0,   6'd0,  32'd0},          1'b1, 8'd255},
        '{'{pdsd_pkg::FN_TICK,        6'd0,  8'd0,   6'd0,  32'd7},          1'b0, 8'd0},
        // unknown funcs do nothing
        '{'{FN_SPARE_LO,              6'd0,  8'd0,   6'd0,  32'd0},          1'b0, 8'd0},
        '{'{FN_SPARE_HI,              6'd63, 8'd255, 6'd63, 32'hFFFF_FFFF},  1'b0, 8'd0},
        '{'{pdsd_pkg::FN_FILL,        6'd0,  8'd0,   6'd0,  32'd0},          1'b0, 8'd0},
        '{'{pdsd_pkg::FN_READ_BRIGHT, 6'd62, 8'd0,   6'd0,  32'd0},          1'b1, 8'd0},
        // brightness at and above the period stays on
        '{'{pdsd_pkg::FN_SET_BRIGHT,  6'd62, 8'd17,  6'd0,  32'd0},          1'b0, 8'd0},
        '{'{pdsd_pkg::FN_SET_BRIGHT,  6'd30, 8'd16,  6'd0,  32'd0},          1'b0, 8'd0},
        '{'{pdsd_pkg::FN_TICK,        6'd0,  8'd0,   6'd0,  32'h8000_000F},  1'b0, 8'd0},
        '{'{pdsd_pkg::FN_READ_BRIGHT, 6'd62, 8'd0,   6'd0,  32'd0},          1'b0, 8'd0}
    };

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // update the shadow state and queue what the item should produce
    task automatic apply_cmd(input t_cmd c);
        logic [pdsd_pkg::TIME_W-1:0]  period;
        logic [pdsd_pkg::TIME_W-1:0]  phase;
        logic [N_DIGITS-1:0]          cathodes;
        logic [pdsd_pkg::COLON_W-1:0] dots;
        t_disp_result                 r;
        case (c.func)
            // every index names a digit or a dot at these sizes
            pdsd_pkg::FN_SET_BRIGHT: bright_mem[c.elem] = c.bright;
            pdsd_pkg::FN_SET_SLOT: begin
                if (c.elem < N_DIGITS && c.slot < N_DIGITS)
                    slot_of[c.elem] = c.slot;
            end
            pdsd_pkg::FN_TICK: begin
                // a zero period acts as one
                period   = (pwm_levels == '0) ? 32'd1 : 32'(pwm_levels);
                phase    = c.time_ms % period;
                cathodes = '1;
                dots     = '0;
                for (int i = 0; i < N_DIGITS; i++)
                    if (32'(bright_mem[i]) > phase)
                        cathodes[slot_of[i]] = 1'b0;
                for (int i = 0; i < N_DOTS; i++)
                    if (32'(bright_mem[int'(pdsd_pkg::DOT_BASE) + i]) > phase)
                        dots[i] = 1'b1;
                // highest slot goes out first, colons ride on the final bit
                for (int i = N_DIGITS - 1; i >= 0; i--) begin
                    r.kind     = pdsd_pkg::RK_SHIFT;
                    r.bit_val  = cathodes[i];
                    r.last     = (i == 0);
                    r.colons   = (i == 0) ? dots : '0;
                    r.read_val = '0;
                    due_results.push_back(r);
                end
            end
            pdsd_pkg::FN_READ_BRIGHT: begin
                r.kind     = pdsd_pkg::RK_READ;
                r.bit_val  = 1'b0;
                r.last     = 1'b0;
                r.colons   = '0;
                r.read_val = bright_mem[c.elem];
                due_results.push_back(r);
            end
            pdsd_pkg::FN_FILL: begin
                for (int i = 0; i < pdsd_pkg::ELEM_N; i++)
                    bright_mem[i] = c.bright;
            end
            default: ;
        endcase
    endtask

    // idle mode 0: sender idles 35%, receiver 58%; mode 1 swapped; else none
    task automatic set_idle(input int mode);
        case (mode)
            0: begin
                src_idle_pct = 35;
                snk_idle_pct = 58;
            end
            1: begin
                src_idle_pct = 58;
                snk_idle_pct = 35;
            end
            default: begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
        endcase
    endtask

    // drive one item and hold it until the block takes it
    task automatic send_cmd(input t_cmd c, input logic typed,
                            input logic [pdsd_pkg::BRIGHT_W-1:0] read_exp);
        t_disp_result r;
        while (int'($urandom_range(99)) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.func          <= c.func;
        in_if.element_index <= c.elem;
        in_if.brightness    <= c.bright;
        in_if.pin_slot      <= c.slot;
        in_if.time_ms       <= c.time_ms;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1)
            @(posedge i_clk);
        if (typed) begin
            r.kind     = pdsd_pkg::RK_READ;
            r.bit_val  = 1'b0;
            r.last     = 1'b0;
            r.colons   = '0;
            r.read_val = read_exp;
            due_results.push_back(r);
        end else begin
            apply_cmd(c);
        end
    endtask

    // stop sending, let every owed result drain, then let the block go quiet
    task automatic settle(input int extra);
        in_if.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_levels(input logic [pdsd_pkg::BRIGHT_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (cfg_if.ready !== 1'b1)
            @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        pwm_levels = value;
    endtask

    function automatic t_cmd rand_cmd();
        t_cmd c;
        int   pick;
        int   lim;
        pick = int'($urandom_range(99));
        if (pick < 28)
            c.func = pdsd_pkg::FN_SET_BRIGHT;
        else if (pick < 42)
            c.func = pdsd_pkg::FN_SET_SLOT;
        else if (pick < 58)
            c.func = pdsd_pkg::FN_TICK;
        else if (pick < 80)
            c.func = pdsd_pkg::FN_READ_BRIGHT;
        else if (pick < 86)
            c.func = pdsd_pkg::FN_FILL;
        else
            c.func = pdsd_pkg::FUNC_W'($urandom_range(FN_SPARE_HI, FN_SPARE_LO));
        c.elem = pdsd_pkg::ELEM_W'($urandom_range(pdsd_pkg::ELEM_N - 1));
        // keep most brightness values near the period so ticks show a real mix
        lim = (pwm_levels == 8'd255) ? 255 : int'(pwm_levels) + 1;
        if ($urandom_range(99) < 70)
            c.bright = pdsd_pkg::BRIGHT_W'($urandom_range(lim));
        else
            c.bright = pdsd_pkg::BRIGHT_W'($urandom_range(255));
        // mostly legal slots, a few past the last one
        if ($urandom_range(99) < 85)
            c.slot = pdsd_pkg::ELEM_W'($urandom_range(N_DIGITS - 1));
        else
            c.slot = pdsd_pkg::ELEM_W'($urandom_range(pdsd_pkg::ELEM_N - 1, N_DIGITS));
        c.time_ms = $urandom();
        return c;
    endfunction

    // result side: check each taken result, then pick the next ready
    always @(posedge i_clk) begin
        t_disp_result want;
        if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (due_results.size() == 0) begin
                report_mismatch("result arrived with nothing due");
            end else begin
                want = due_results.pop_front();
                check_field("result_kind",  8'(out_if.result_kind),  8'(want.kind));
                check_field("serial_bit",   8'(out_if.serial_bit),   8'(want.bit_val));
                check_field("last",         8'(out_if.last),         8'(want.last));
                check_field("colon_levels", 8'(out_if.colon_levels), 8'(want.colons));
                check_field("read_value",   out_if.read_value,       want.read_val);
            end
        end
        out_if.ready <= (int'($urandom_range(99)) >= snk_idle_pct);
    end

    initial begin
        logic [pdsd_pkg::BRIGHT_W-1:0] lv;
        // every input known from time zero
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.func          = pdsd_pkg::FN_SET_BRIGHT;
        in_if.element_index = '0;
        in_if.brightness    = '0;
        in_if.pin_slot      = '0;
        in_if.time_ms       = '0;
        out_if.ready        = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.data         = '0;
        err_cnt             = 0;
        set_idle(0);

        // shadow state after reset
        pwm_levels = pdsd_pkg::LEVELS_RESET;
        for (int i = 0; i < pdsd_pkg::ELEM_N; i++)
            bright_mem[i] = '0;
        for (int i = 0; i < N_DIGITS; i++)
            slot_of[i] = pdsd_pkg::ELEM_W'(i);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass at the reset period
        foreach (dir_tab[k])
            send_cmd(dir_tab[k].cmd, dir_tab[k].typed, dir_tab[k].read_exp);

        // random phases, each at its own period; the drain before each
        // write also makes the sender wait for every owed result
        for (int p = 0; p < N_PHASES; p++) begin
            settle(SETTLE_CYCLES);
            case (p)
                0: lv = 8'd255;
                1: lv = 8'd1;
                2: lv = pdsd_pkg::BRIGHT_W'($urandom_range(254, 2));
                3: lv = 8'd0;
                4: lv = pdsd_pkg::BRIGHT_W'($urandom_range(40, 2));
                default: lv = pdsd_pkg::LEVELS_RESET;
            endcase
            write_levels(lv);
            set_idle(p / 2);
            repeat (ITEMS_PER_PHASE)
                send_cmd(rand_cmd(), 1'b0, 8'd0);
        end

        settle(TAIL_CYCLES);
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== pwm_display_shift_driver.f =====
src/pdsd_pkg.sv
src/pdsd_in_if.sv
src/pdsd_out_if.sv
src/pdsd_cfg_if.sv
src/pdsd_ram.sv
src/pwm_display_shift_driver.sv
dv/pwm_display_shift_driver_tb.sv
